### hw/rtl/spoc_pkg.sv
// shared types and constants for the stack pop-order checker
package spoc_pkg;

    localparam int MAX_LENGTH_DEF  = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W     = 2;
    localparam int DATA_W       = 32;
    localparam int POP_INDEX_W  = 9;
    localparam int OUT_DATA_W   = 16;
    localparam logic [POP_INDEX_W-1:0] POP_INDEX_MAX = 9'd256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_CHECK = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PUSH,
        ST_RELOAD,
        ST_RESULT
    } state_t;

endpackage

### hw/rtl/spoc_ram.sv
// generic simple dual-port ram with registered read
module spoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/stack_pop_order_checker.sv
// stack pop-order checker top level
//
// A start request (tuser 0) clears the job, a load request (tuser 1) appends a
// push-order value or, when the ram is full, fails the job, and a check request
// (tuser 2) answers with one result: whether every pop value of the job so far
// matched the top of an internal stack, and the saturating count of checks. A check
// pushes stored values until the top matches, and a pop that leaves a value below
// the top fetches it from the stack ram; a check on a job that has already failed or
// has nothing loaded goes straight to its result. The push-order ram and the stack
// ram both have a registered read. A check also holds in its result state while the
// previous result still waits in the output register. Every stored value is pushed
// at most once per job. A result may wait in the output register while the next
// request is taken.
module stack_pop_order_checker
    import spoc_pkg::*;
#(
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // value
    input  logic [ACTION_W-1:0]   s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // consistent, pop_index, zero fill
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       loaded_reg, loaded_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       height_reg, height_next;
    logic [POP_INDEX_W-1:0] checked_reg, checked_next;
    logic                   failed_reg, failed_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_consistent_reg, out_consistent_next;
    logic [POP_INDEX_W-1:0] out_index_reg, out_index_next;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [CNT_W-1:0]       height_m1, height_m2;

    logic                   push_we;
    logic [VALUE_WIDTH-1:0] push_rdata;
    logic                   stack_we;
    logic [VALUE_WIDTH-1:0] stack_rdata;

    assign accept    = s_tvalid && s_tready;
    assign in_value  = VALUE_WIDTH'(s_tdata);
    assign height_m1 = height_reg - CNT_W'(1);
    assign height_m2 = height_reg - CNT_W'(2);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - POP_INDEX_W - 1){1'b0}}, out_index_reg,
                       out_consistent_reg};

    spoc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_LENGTH)
    ) u_push_ram (
        .clk   (clk),
        .we    (push_we),
        .waddr (loaded_reg[ADDR_W-1:0]),
        .wdata (in_value),
        .raddr (ptr_reg[ADDR_W-1:0]),
        .rdata (push_rdata)
    );

    // the top of stack lives in top_reg, the ram holds the entries below it
    spoc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_LENGTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (height_m1[ADDR_W-1:0]),
        .wdata (top_reg),
        .raddr (height_m2[ADDR_W-1:0]),
        .rdata (stack_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            ptr_reg       <= '0;
            height_reg    <= '0;
            checked_reg   <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            ptr_reg       <= ptr_next;
            height_reg    <= height_next;
            checked_reg   <= checked_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg          <= value_next;
        top_reg            <= top_next;
        out_consistent_reg <= out_consistent_next;
        out_index_reg      <= out_index_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        loaded_next         = loaded_reg;
        ptr_next            = ptr_reg;
        height_next         = height_reg;
        checked_next        = checked_reg;
        failed_next         = failed_reg;
        value_next          = value_reg;
        top_next            = top_reg;
        out_valid_next      = out_valid_reg && !m_tready;
        out_consistent_next = out_consistent_reg;
        out_index_next      = out_index_reg;
        push_we             = 1'b0;
        stack_we            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(s_tuser))
                        ACT_START:
                        begin
                            loaded_next  = '0;
                            ptr_next     = '0;
                            height_next  = '0;
                            checked_next = '0;
                            failed_next  = 1'b0;
                        end
                        ACT_LOAD:
                        begin
                            if (loaded_reg < MAX_CNT)
                            begin
                                push_we     = 1'b1;
                                loaded_next = loaded_reg + CNT_W'(1);
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        ACT_CHECK:
                        begin
                            value_next = in_value;
                            if (checked_reg < POP_INDEX_MAX)
                            begin
                                checked_next = checked_reg + POP_INDEX_W'(1);
                            end
                            if (failed_reg)
                            begin
                                state_next = ST_RESULT;
                            end
                            else if (loaded_reg == '0)
                            begin
                                failed_next = 1'b1;
                                state_next  = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                if ((height_reg != '0) && (top_reg == value_reg))
                begin
                    height_next = height_m1;
                    // the new top must come back from the stack ram
                    state_next  = (height_reg > CNT_W'(1)) ? ST_RELOAD : ST_RESULT;
                end
                else if ((ptr_reg < loaded_reg) && (height_reg < MAX_CNT))
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    failed_next = 1'b1;
                    state_next  = ST_RESULT;
                end
            end

            ST_PUSH:
            begin
                stack_we    = (height_reg != '0);
                top_next    = push_rdata;
                height_next = height_reg + CNT_W'(1);
                ptr_next    = ptr_reg + CNT_W'(1);
                state_next  = ST_CHECK;
            end

            ST_RELOAD:
            begin
                top_next   = stack_rdata;
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next      = 1'b1;
                    out_consistent_next = !failed_reg;
                    out_index_next      = checked_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
